/* sv/cwms_pkg.sv */
`default_nettype none
package cwms_pkg;

   localparam int unsigned FRAC_BITS  = 8;
   localparam int unsigned OUT_W      = 20;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned WL_W       = 5;
   localparam int unsigned SEEN_W     = 6;
   localparam int unsigned CSR_IDX_W  = 4;

   localparam logic [SEEN_W-1:0] SEEN_MAX     = {SEEN_W{1'b1}};
   localparam int                OUT_MAX      = 524287;
   localparam logic [OUT_W-1:0]  OUT_MAX_BITS = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0]  OUT_MIN_BITS = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LEN = 4'd0,
      CSR_MODE       = 4'd1
   } csr_idx_type;

   // per-item control handed from front to back
   typedef struct packed {
      logic              window;
      logic              last;
      logic [SEEN_W-1:0] pad;
   } ctl_type;

endpackage
`default_nettype wire

/* sv/centerline_window_mean_and_slope_core.sv */
`default_nettype none
// Sliding-window mean/slope of a 3-D centerline. Points enter on req_ (x, y, z in tdata,
// end of line on tlast); each point, once the line has 2m points (m = window_len clamped
// to 1..MAX_WINDOW), gives one result on rsp_: the older m-point window mean (mode 0) or
// newer minus older window mean (mode 1), signed with 8 fraction bits, truncated toward
// zero and saturated. The last point is followed by min(size, 2m-1) zero results flagged
// in tuser, the final one with tlast, so a line of size points gives size results. A
// point that completes a window is handled in the back end by 2m reads through the
// single read port of the point history plus read latency, a 24-step (COORD_BITS +
// clog2(MAX_WINDOW+1) + 8) bit-serial divider, one per axis, and the output register.
// A two-entry queue separates input acceptance from processing. Write window_len and
// mode only while idle.
module centerline_window_mean_and_slope_core #(
   parameter int MAX_WINDOW = 16,
   parameter int COORD_BITS = 11
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   // x_in, y_in, z_in from bit 0 up, zero filled
   input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   input  wire logic                                   req_tlast,
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // x_out, y_out, z_out from bit 0 up, zero filled
   output      logic [cwms_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // padded
   output      logic [0:0]                             rsp_tuser,
   output      logic                                   rsp_tlast,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [cwms_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [cwms_pkg::WL_W-1:0]              csr_data
);

   localparam int C     = COORD_BITS;
   localparam int DEPTH = 2 * MAX_WINDOW;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W = COORD_BITS + $clog2(MAX_WINDOW + 1);
   localparam int WL_W  = cwms_pkg::WL_W;
   localparam int QW    = $bits(cwms_pkg::ctl_type) + PTR_W + 3 * C;

   logic [WL_W-1:0]  wl_ff;
   logic             mode_ff;
   logic [WL_W-1:0]  m;
   logic [WL_W:0]    twom;

   logic                 accept;
   logic [PTR_W-1:0]     f_slot, q_slot;
   cwms_pkg::ctl_type    f_ctl, q_ctl;
   logic                 q_full, q_valid, q_pop;
   logic [QW-1:0]        q_head;
   logic [3*C-1:0]       q_pt;
   logic [3*cwms_pkg::OUT_W-1:0] rsp_xyz;

   always_comb begin
      if (wl_ff == '0) begin
         m = WL_W'(1);
      end else if ({1'b0, wl_ff} > (WL_W+1)'(MAX_WINDOW)) begin
         m = WL_W'(MAX_WINDOW);
      end else begin
         m = wl_ff;
      end
      twom = {m, 1'b0};
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff   <= WL_W'(1);
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            cwms_pkg::CSR_WINDOW_LEN: wl_ff   <= csr_data;
            cwms_pkg::CSR_MODE:       mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   cwms_front #(.PTR_W(PTR_W), .DEPTH(DEPTH)) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .last   (req_tlast),
      .twom   (twom),
      .slot   (f_slot),
      .ctl    (f_ctl)
   );

   cwms_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({f_ctl, f_slot, req_tdata[3*C-1:0]}),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   assign {q_ctl, q_slot, q_pt} = q_head;

   cwms_back #(
      .COORD_BITS (COORD_BITS),
      .MAX_WINDOW (MAX_WINDOW),
      .PTR_W      (PTR_W),
      .DEPTH      (DEPTH),
      .SUM_W      (SUM_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pt       (q_pt),
      .q_slot     (q_slot),
      .q_ctl      (q_ctl),
      .q_pop      (q_pop),
      .m          (m),
      .twom       (twom),
      .mode       (mode_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_xyz    (rsp_xyz),
      .rsp_pad    (rsp_tuser[0]),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(cwms_pkg::RSP_DATA_W - 3*cwms_pkg::OUT_W){1'b0}}, rsp_xyz};

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   a_last_is_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("line end on a computed item");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("padding item carries data");

endmodule
`default_nettype wire

/* sv/cwms_front.sv */
`default_nettype none
module cwms_front #(
   parameter int PTR_W = 5,
   parameter int DEPTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          last,
   input  wire logic [cwms_pkg::WL_W:0]       twom,
   output      logic [PTR_W-1:0]              slot,
   output      cwms_pkg::ctl_type             ctl
);

   logic [cwms_pkg::SEEN_W-1:0] seen_ff, seen_in, seen_new;
   logic [PTR_W-1:0]            ptr_ff, ptr_in;
   logic [cwms_pkg::SEEN_W-1:0] twom_s, twom_m1;

   always_comb begin
      twom_s   = cwms_pkg::SEEN_W'(twom);
      twom_m1  = twom_s - cwms_pkg::SEEN_W'(1);
      seen_new = (seen_ff == cwms_pkg::SEEN_MAX) ? seen_ff : seen_ff + cwms_pkg::SEEN_W'(1);
      ctl.window = (seen_new >= twom_s);
      ctl.last   = last;
      ctl.pad    = (seen_new < twom_m1) ? seen_new : twom_m1;
      slot       = ptr_ff;
      seen_in    = seen_ff;
      ptr_in     = ptr_ff;
      if (accept) begin
         if (last) begin
            seen_in = '0;
            ptr_in  = '0;
         end else begin
            seen_in = seen_new;
            ptr_in  = (ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         seen_ff <= seen_in;
         ptr_ff  <= ptr_in;
      end
   end

endmodule
`default_nettype wire

/* sv/cwms_queue.sv */
`default_nettype none
module cwms_queue #(
   parameter int W = 48
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   input  wire logic         pop,
   output      logic         full,
   output      logic         valid,
   output      logic [W-1:0] head
);

   logic [W-1:0] ent_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign head  = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

/* sv/cwms_div.sv */
`default_nettype none
module cwms_div #(
   parameter int SUM_W = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [SUM_W:0]             num,
   input  wire logic [cwms_pkg::WL_W-1:0]         m,
   output      logic                              done,
   output      logic signed [cwms_pkg::OUT_W-1:0] quo
);

   localparam int DVD_W = SUM_W + cwms_pkg::FRAC_BITS;
   localparam int CNT_W = $clog2(DVD_W);
   localparam int QX_W  = (DVD_W > cwms_pkg::OUT_W + 1) ? DVD_W : cwms_pkg::OUT_W + 1;
   localparam int WL_W  = cwms_pkg::WL_W;

   logic [DVD_W-1:0] dq_ff;
   logic [WL_W-1:0]  rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             neg_ff, busy_ff, done_ff;

   logic [SUM_W:0]   neg_num;
   logic [SUM_W-1:0] mag;
   logic [WL_W:0]    trial, diff;
   logic             ge;
   logic [QX_W-1:0]  qx, qneg;

   always_comb begin
      neg_num = -num;
      mag     = num[SUM_W] ? neg_num[SUM_W-1:0] : num[SUM_W-1:0];
      trial   = {rem_ff, dq_ff[DVD_W-1]};
      diff    = trial - {1'b0, m};
      ge      = (trial >= {1'b0, m});
      qx      = QX_W'(dq_ff);
      qneg    = QX_W'(0) - qx;
      if (!neg_ff) begin
         quo = (qx > QX_W'(cwms_pkg::OUT_MAX)) ? cwms_pkg::OUT_MAX_BITS
                                              : qx[cwms_pkg::OUT_W-1:0];
      end else begin
         quo = (qx > QX_W'(cwms_pkg::OUT_MAX) + QX_W'(1)) ? cwms_pkg::OUT_MIN_BITS
                                                         : qneg[cwms_pkg::OUT_W-1:0];
      end
   end

   assign done = done_ff;

   // restoring division, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W - 1);
            dq_ff   <= {mag, {cwms_pkg::FRAC_BITS{1'b0}}};
            rem_ff  <= '0;
            neg_ff  <= num[SUM_W];
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[WL_W-1:0] : trial[WL_W-1:0];
            dq_ff  <= {dq_ff[DVD_W-2:0], ge};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

/* sv/cwms_back.sv */
`default_nettype none
module cwms_back #(
   parameter int COORD_BITS = 11,
   parameter int MAX_WINDOW = 16,
   parameter int PTR_W      = 5,
   parameter int DEPTH      = 32,
   parameter int SUM_W      = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   input  wire logic [3*COORD_BITS-1:0]        q_pt,
   input  wire logic [PTR_W-1:0]               q_slot,
   input  wire cwms_pkg::ctl_type              q_ctl,
   output      logic                           q_pop,
   input  wire logic [cwms_pkg::WL_W-1:0]      m,
   input  wire logic [cwms_pkg::WL_W:0]        twom,
   input  wire logic                           mode,
   input  wire logic                           rsp_tready,
   output      logic                           rsp_tvalid,
   output      logic [3*cwms_pkg::OUT_W-1:0]   rsp_xyz,
   output      logic                           rsp_pad,
   output      logic                           rsp_last
);

   localparam int C    = COORD_BITS;
   localparam int KW   = $clog2(2 * MAX_WINDOW + 1);
   localparam int AW   = PTR_W + 2;
   localparam int OW   = cwms_pkg::OUT_W;
   localparam int SW   = cwms_pkg::SEEN_W;

   typedef enum logic [2:0] {ST_IDLE, ST_SUM, ST_DIV, ST_OUT, ST_PAD} state_type;

   state_type        state_ff;
   logic [3*C-1:0]   hist [DEPTH];
   logic [3*C-1:0]   rd_data_ff;
   logic [PTR_W-1:0] rd_addr_ff;
   logic [KW-1:0]    kcnt_ff;
   logic             rd_vld_ff, rd_old_ff;
   logic [SUM_W-1:0] old_ff [3];
   logic [SUM_W-1:0] new_ff [3];
   logic             last_ff;
   logic [SW-1:0]    pad_ff, padcnt_ff;
   logic             out_valid_ff, out_pad_ff, out_last_ff;
   logic [3*OW-1:0]  out_xyz_ff;

   logic               out_free, out_set, div_start, pop;
   logic [AW-1:0]      start_raw, start_addr;
   logic [KW-1:0]      twom_k, m_k;
   logic [2:0]         div_done;
   logic signed [SUM_W:0]  num [3];
   logic signed [OW-1:0]   quo [3];

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      out_set    = ((state_ff == ST_OUT) || (state_ff == ST_PAD)) && out_free;
      pop        = (state_ff == ST_IDLE) && q_valid;
      twom_k     = KW'(twom);
      m_k        = KW'(m);
      div_start  = (state_ff == ST_SUM) && (kcnt_ff == twom_k) && !rd_vld_ff;
      start_raw  = AW'(q_slot) + AW'(1) + AW'(DEPTH) - AW'(twom);
      start_addr = (start_raw >= AW'(DEPTH)) ? start_raw - AW'(DEPTH) : start_raw;
      for (int a = 0; a < 3; a++) begin
         num[a] = mode ? $signed({1'b0, new_ff[a]}) - $signed({1'b0, old_ff[a]})
                       : $signed({1'b0, old_ff[a]});
      end
   end

   assign q_pop      = pop;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_xyz    = out_xyz_ff;
   assign rsp_pad    = out_pad_ff;
   assign rsp_last   = out_last_ff;

   for (genvar a = 0; a < 3; a++) begin : g_div
      cwms_div #(.SUM_W(SUM_W)) u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .num   (num[a]),
         .m     (m),
         .done  (div_done[a]),
         .quo   (quo[a])
      );
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         hist[q_slot] <= q_pt;
      end
      rd_data_ff <= hist[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready && !out_set) begin
            out_valid_ff <= 1'b0;
         end
         if (rd_vld_ff) begin
            for (int a = 0; a < 3; a++) begin
               if (rd_old_ff) begin
                  old_ff[a] <= old_ff[a] + SUM_W'(rd_data_ff[a*C +: C]);
               end else begin
                  new_ff[a] <= new_ff[a] + SUM_W'(rd_data_ff[a*C +: C]);
               end
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  for (int a = 0; a < 3; a++) begin
                     old_ff[a] <= '0;
                     new_ff[a] <= '0;
                  end
                  last_ff    <= q_ctl.last;
                  pad_ff     <= q_ctl.pad;
                  padcnt_ff  <= '0;
                  kcnt_ff    <= '0;
                  rd_addr_ff <= PTR_W'(start_addr);
                  if (q_ctl.window) begin
                     state_ff <= ST_SUM;
                  end else if (q_ctl.last) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_SUM: begin
               rd_vld_ff <= (kcnt_ff < twom_k);
               rd_old_ff <= (kcnt_ff < m_k);
               if (kcnt_ff < twom_k) begin
                  kcnt_ff    <= kcnt_ff + KW'(1);
                  rd_addr_ff <= (rd_addr_ff == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_addr_ff + PTR_W'(1);
               end
               if (div_start) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (&div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_xyz_ff   <= {quo[2], quo[1], quo[0]};
                  out_pad_ff   <= 1'b0;
                  out_last_ff  <= 1'b0;
                  state_ff     <= last_ff ? ST_PAD : ST_IDLE;
               end
            end
            ST_PAD: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_xyz_ff   <= '0;
                  out_pad_ff   <= 1'b1;
                  out_last_ff  <= (padcnt_ff + SW'(1) == pad_ff);
                  padcnt_ff    <= padcnt_ff + SW'(1);
                  if (padcnt_ff + SW'(1) == pad_ff) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
